### design/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg: shared types and constants for the indentation stack checker
// Item layouts, line records passed from front to back, and status codes.
// ----------------------------------------------------------------------------
package isc_pkg;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam int         QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_BLOCK   = 3'd1,
        ST_UNEXPECTED = 3'd2,
        ST_MISMATCH   = 3'd3,
        ST_OVERFLOW   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] line_number;
    } t_out_item;

    // One finished line, as seen by the stack check
    typedef struct packed {
        logic [7:0] indent;
        logic       colon;
    } t_line_rec;

endpackage

### design/isc_front.sv
// ----------------------------------------------------------------------------
// isc_front: character scanner
// Counts leading non-letter characters per line and emits one line record
// at each line end.
// ----------------------------------------------------------------------------
module isc_front import isc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    input  logic      i_q_full,
    output logic      o_push,
    output t_line_rec o_rec
);

    logic [7:0] r_indent;
    logic [7:0] n_indent;
    logic       r_letter_seen;
    logic       n_letter_seen;
    logic       w_accept;
    logic       w_letter;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_letter = is_letter(i_item.character);

    always_comb begin
        n_letter_seen = r_letter_seen || w_letter;
        n_indent      = r_indent;
        // count this character toward the indent, saturate at 255
        if (!r_letter_seen && !w_letter && (r_indent != 8'hFF)) begin
            n_indent = r_indent + 8'd1;
        end
    end

    assign o_push       = w_accept && i_item.end_of_line;
    assign o_rec.indent = n_indent;
    assign o_rec.colon  = (i_item.character == COLON_CHAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_indent      <= 8'd0;
            r_letter_seen <= 1'b0;
        end else if (w_accept) begin
            if (i_item.end_of_line) begin
                r_indent      <= 8'd0;
                r_letter_seen <= 1'b0;
            end else begin
                r_indent      <= n_indent;
                r_letter_seen <= n_letter_seen;
            end
        end
    end

endmodule

### design/isc_fifo.sv
// ----------------------------------------------------------------------------
// isc_fifo: line record queue
// Two-entry queue that decouples the scanner from the stack check.
// ----------------------------------------------------------------------------
module isc_fifo import isc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_line_rec i_rec,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_line_rec o_rec
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_line_rec        r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW:0]      r_count;

    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

endmodule

### design/isc_back.sv
// ----------------------------------------------------------------------------
// isc_back: indentation stack check
// Checks each line record against the open block stack, updates the stack,
// and registers one result per checked line.
// ----------------------------------------------------------------------------
module isc_back import isc_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_line_rec i_q_rec,
    output logic      o_q_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_CLEAR
    } t_stack_op;

    logic [7:0]       r_stack [STACK_DEPTH];
    logic [CW-1:0]    r_count;
    logic [7:0]       r_top;
    logic             r_expect;
    logic [15:0]      r_line;
    logic             r_failed;
    logic             r_out_valid;
    t_out_item        r_out;

    logic                   w_take;
    logic                   w_load;
    logic [STACK_DEPTH-1:0] w_match;
    logic [IW-1:0]          w_match_idx;
    t_status                w_status;
    t_stack_op              w_op;

    assign w_take  = i_q_valid && (!r_out_valid || i_ready);
    assign w_load  = w_take && !r_failed;
    assign o_q_pop = w_take;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // compare the indent against every open level at once
    always_comb begin
        w_match_idx = '0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            w_match[i] = (CW'(i) < r_count) && (r_stack[i] == i_q_rec.indent);
        end
        for (int i = STACK_DEPTH - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_match_idx = IW'(i);
            end
        end
    end

    always_comb begin
        w_status = ST_OK;
        w_op     = OP_NONE;
        if (r_expect) begin
            if (i_q_rec.indent <= r_top) begin
                w_status = ST_NO_BLOCK;
            end else if (r_count >= CW'(STACK_DEPTH)) begin
                w_status = ST_OVERFLOW;
            end else begin
                w_op = OP_PUSH;
            end
        end else if (i_q_rec.indent > r_top) begin
            w_status = ST_UNEXPECTED;
        end else if (i_q_rec.indent < r_top) begin
            if (i_q_rec.indent == 8'd0) begin
                w_op = OP_CLEAR;
            end else if (|w_match) begin
                w_op = OP_POP;
            end else begin
                w_status = ST_MISMATCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && (w_op == OP_PUSH)) begin
            r_stack[r_count[IW-1:0]] <= i_q_rec.indent;
        end
        if (w_load) begin
            r_out.status      <= w_status;
            r_out.line_number <= r_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_top       <= 8'd0;
            r_expect    <= 1'b0;
            r_line      <= 16'd1;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                if (w_status != ST_OK) begin
                    r_failed <= 1'b1;
                end else begin
                    r_expect <= i_q_rec.colon;
                    if (r_line != 16'hFFFF) begin
                        r_line <= r_line + 16'd1;
                    end
                    unique case (w_op)
                        OP_PUSH: begin
                            r_count <= r_count + CW'(1);
                            r_top   <= i_q_rec.indent;
                        end
                        OP_POP: begin
                            r_count <= CW'(w_match_idx) + CW'(1);
                            r_top   <= i_q_rec.indent;
                        end
                        OP_CLEAR: begin
                            r_count <= '0;
                            r_top   <= 8'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |=> r_failed)
        else $error("error flag cleared");

    a_no_result_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> !w_load)
        else $error("line checked after error");

    a_error_sets_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_status != ST_OK)) |=> (r_failed && o_valid))
        else $error("error result did not set error flag");
`endif

endmodule

### design/indentation_stack_checker_unit.sv
// Path: a line-end item's record is registered in the line queue, then its result is registered onto o_item.
// Throughput: one character item per cycle while the line queue is not full; the line indent
// is compared against all open stack levels at once, in combinational logic.
// Reset: synchronous, active low; clears stack count, line number to 1 and error flag.
// The stack entries themselves are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// indentation_stack_checker_unit: offside rule indentation checker
// Scanner front end, two-entry line queue, and stack check back end.
// ----------------------------------------------------------------------------
module indentation_stack_checker_unit import isc_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic      w_push;
    logic      w_full;
    logic      w_pop;
    logic      w_q_valid;
    t_line_rec w_rec_in;
    t_line_rec w_rec_out;

    isc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_rec    (w_rec_in)
    );

    isc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_rec   (w_rec_out)
    );

    isc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_rec   (w_rec_out),
        .o_q_pop   (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

endmodule

### sim/indentation_stack_checker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indentation_stack_checker_unit_tb: self-checking bench for the indent checker
// Feeds source lines one character per item. Most lines are well formed and
// drive the open-level stack through pushes, pops and clears. One random
// indentation error ends the checked part, and trailing noise must then
// produce nothing. Every result is checked against a line-level predictor
// kept in this bench.
// ----------------------------------------------------------------------------
module indentation_stack_checker_unit_tb;
    import isc_pkg::*;

    localparam int STACK_DEPTH  = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int END_CYCLES   = 10;
    localparam int PHASE_ITEMS  = 120;
    localparam int TAIL_LINES   = 8;
    localparam int NOISE_ITEMS  = 30;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    indentation_stack_checker_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_item (o_item)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and handshake bookkeeping
    t_in_item  pending_chars[$];
    t_out_item line_results_due[$];
    int        queued_count   = 0;
    int        accepted_count = 0;
    int        send_idle_pct  = 33;
    int        recv_idle_pct  = 46;
    int        hold_requests  = 0;
    int        holds_done     = 0;
    int        hold_left      = 0;
    int        stall_cycles   = 0;
    int        error_count    = 0;
    bit        in_taken       = 1'b0;
    t_out_item got_line;
    t_out_item want_line;

    // Predicted checker state
    logic [7:0]  open_level[STACK_DEPTH];
    int          level_count   = 0;
    int          deepest       = 0;
    logic        block_due     = 1'b0;
    logic        letter_found  = 1'b0;
    logic        failed_seen   = 1'b0;
    logic [7:0]  indent_run    = 8'd0;
    logic [15:0] line_no       = 16'd1;
    int          status_tally[5];
    t_status     terminal      = ST_OK;

    // Planned stack, used only to shape well-formed lines
    int plan_levels[$];
    bit plan_expect = 1'b0;
    int plan_lines  = 0;

    function automatic bit is_letter(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic void scan_char(t_in_item it);
        logic [7:0] indent;
        logic [7:0] top;
        t_status    st;
        t_out_item  res;
        int         k;
        if (!letter_found) begin
            if (is_letter(it.character))
                letter_found = 1'b1;
            else if (indent_run != 8'hFF)
                indent_run++;
        end
        if (!it.end_of_line)
            return;
        indent = indent_run;
        indent_run = 8'd0;
        letter_found = 1'b0;
        if (failed_seen)
            return;
        top = (level_count != 0) ? open_level[level_count - 1] : 8'd0;
        st = ST_OK;
        if (block_due) begin
            if (indent <= top) begin
                st = ST_NO_BLOCK;
            end else if (level_count >= STACK_DEPTH) begin
                st = ST_OVERFLOW;
            end else begin
                open_level[level_count] = indent;
                level_count++;
            end
        end else if (indent > top) begin
            st = ST_UNEXPECTED;
        end else if (indent < top) begin
            if (indent == 8'd0) begin
                level_count = 0;
            end else begin
                // pop back to the matching outer level
                st = ST_MISMATCH;
                for (k = 0; k < level_count; k++) begin
                    if (open_level[k] == indent) begin
                        level_count = k + 1;
                        st = ST_OK;
                        break;
                    end
                end
            end
        end
        res.status = st;
        res.line_number = line_no;
        line_results_due = {line_results_due, res};
        status_tally[st]++;
        if (level_count > deepest)
            deepest = level_count;
        if (st != ST_OK) begin
            failed_seen = 1'b1;
            terminal = st;
        end else begin
            block_due = (it.character == COLON_CHAR);
            if (line_no != 16'hFFFF)
                line_no++;
        end
    endfunction

    function automatic void push_char(logic [7:0] c, logic eol);
        t_in_item it;
        it.character = c;
        it.end_of_line = eol;
        pending_chars = {pending_chars, it};
        queued_count++;
    endfunction

    function automatic logic [7:0] non_letter();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (is_letter(c))
            c = 8'($urandom_range(255));
        return c;
    endfunction

    function automatic logic [7:0] any_letter();
        if ($urandom_range(1) != 0)
            return 8'h41 + 8'($urandom_range(25));
        return 8'h61 + 8'($urandom_range(25));
    endfunction

    function automatic int plan_top();
        return (plan_levels.size() != 0) ? plan_levels[plan_levels.size() - 1] : 0;
    endfunction

    function automatic void plan_line(int indent, bit colon);
        if (plan_expect)
            plan_levels = {plan_levels, indent};
        else if (indent == 0)
            plan_levels.delete();
        else
            while (plan_levels.size() != 0 && plan_top() > indent)
                void'(plan_levels.pop_back());
        plan_expect = colon;
        plan_lines++;
    endfunction

    // pad leading non-letters; a letterless line is pad characters long
    function automatic void emit_line(int pad, bit colon, bit letterless, int trail);
        int         len;
        int         k;
        logic [7:0] c;
        if (!letterless && colon && trail == 0)
            trail = 1;
        len = letterless ? pad : pad + 1 + trail;
        for (k = 0; k < len; k++) begin
            if (letterless || k < pad)
                c = non_letter();
            else if (k == pad)
                c = any_letter();
            else
                c = 8'($urandom_range(255));
            if (k == len - 1) begin
                if (colon)
                    c = COLON_CHAR;
                else
                    while (c == COLON_CHAR)
                        c = letterless ? non_letter() : 8'($urandom_range(255));
            end
            push_char(c, k == len - 1);
        end
        plan_line((pad > 255) ? 255 : pad, colon);
    endfunction

    function automatic void random_ok_line(int max_trail);
        int cnt;
        int top;
        int indent;
        int idx;
        int new_cnt;
        int new_top;
        int r;
        bit colon;
        bit letterless;
        cnt = plan_levels.size();
        top = plan_top();
        r = $urandom_range(9);
        if (plan_expect) begin
            indent = top + $urandom_range(1, 4);
            new_cnt = cnt + 1;
            new_top = indent;
        end else if (r < 5 || cnt == 0) begin
            indent = top;
            new_cnt = cnt;
            new_top = top;
        end else if (r < 8) begin
            idx = $urandom_range(cnt - 1);
            indent = plan_levels[idx];
            new_cnt = idx + 1;
            new_top = indent;
        end else begin
            indent = 0;
            new_cnt = 0;
            new_top = 0;
        end
        // keep the next push legal
        colon = new_cnt < STACK_DEPTH && new_top <= 240 && $urandom_range(99) < 45;
        letterless = indent > 0 && $urandom_range(9) == 0;
        emit_line(indent, colon, letterless, $urandom_range(max_trail));
    endfunction

    task automatic wait_drained();
        @(posedge i_clk);
        #1;
        while (accepted_count != queued_count || line_results_due.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    // Driver: hold the item until accepted, then maybe idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_item  <= pending_chars.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus long hold-offs on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: check results, then advance the predictor
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            got_line = o_item;
            if (line_results_due.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: expected none, got status %0d line %0d",
                         $time, got_line.status, got_line.line_number);
            end else begin
                want_line = line_results_due.pop_front();
                if (got_line.status !== want_line.status) begin
                    error_count++;
                    $display("%0t: status on line %0d: expected %0d (%s), got %0d",
                             $time, want_line.line_number, want_line.status,
                             want_line.status.name(), got_line.status);
                end
                if (got_line.line_number !== want_line.line_number) begin
                    error_count++;
                    $display("%0t: line number: expected %0d, got %0d",
                             $time, want_line.line_number, got_line.line_number);
                end
            end
        end
        if (in_taken) begin
            accepted_count++;
            scan_char(i_item);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, line_results_due.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int      start;
        int      k;
        t_status ending;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: letter boundaries as indent, push, pop, clear, saturated indent
        push_char("Z", 1'b0);
        push_char(COLON_CHAR, 1'b1);
        plan_line(0, 1'b1);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(8'h40, 1'b0);
        push_char(8'h5B, 1'b0);
        push_char(8'h60, 1'b0);
        push_char(8'h7B, 1'b0);
        push_char("a", 1'b0);
        push_char(8'hFF, 1'b1);
        plan_line(6, 1'b0);
        push_char("A", 1'b0);
        push_char(8'h00, 1'b1);
        plan_line(0, 1'b0);
        emit_line(0, 1'b1, 1'b0, 1);
        emit_line(4, 1'b0, 1'b0, 2);
        emit_line(4, 1'b1, 1'b0, 2);
        emit_line(8, 1'b1, 1'b1, 0);
        emit_line(12, 1'b0, 1'b0, 1);
        emit_line(4, 1'b0, 1'b0, 1);
        emit_line(0, 1'b1, 1'b0, 1);
        emit_line(256, 1'b0, 1'b0, 1);
        emit_line(0, 1'b0, 1'b0, 0);
        wait_drained();

        // Random lines; hold the receiver off long enough to back up the input
        hold_requests++;
        start = queued_count;
        while (queued_count - start < PHASE_ITEMS)
            random_ok_line(6);
        wait_drained();

        send_idle_pct = 46;
        recv_idle_pct = 33;
        start = queued_count;
        while (queued_count - start < PHASE_ITEMS)
            random_ok_line(6);
        wait_drained();

        // No idling: a few more lines, then end on one error kind
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < TAIL_LINES; k++)
            random_ok_line(4);
        if (plan_expect)
            emit_line(plan_top() + 1, 1'b0, 1'b0, 1);
        ending = t_status'($urandom_range(ST_NO_BLOCK, ST_OVERFLOW));
        case (ending)
            ST_NO_BLOCK: begin
                emit_line(plan_top(), 1'b1, 1'b0, 1);
                emit_line($urandom_range(plan_top()), 1'b0, 1'b0, 1);
            end
            ST_UNEXPECTED: begin
                emit_line(plan_top() + $urandom_range(1, 5), 1'b0, 1'b0, 1);
            end
            ST_MISMATCH: begin
                emit_line(0, 1'b1, 1'b0, 1);
                emit_line(3, 1'b0, 1'b0, 1);
                emit_line($urandom_range(1, 2), 1'b0, 1'b0, 1);
            end
            default: begin
                emit_line(0, 1'b1, 1'b0, 1);
                for (k = 1; k <= STACK_DEPTH; k++)
                    emit_line(k, 1'b1, 1'b0, 1);
                emit_line(STACK_DEPTH + 1, 1'b0, 1'b0, 1);
            end
        endcase
        // Noise after the error must be swallowed
        for (k = 0; k < NOISE_ITEMS; k++)
            push_char(8'($urandom_range(255)), $urandom_range(3) == 0);
        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Covered %0d characters and %0d line results (%0d ok), nesting up to %0d.",
                 accepted_count, status_tally[0] + status_tally[1] + status_tally[2]
                 + status_tally[3] + status_tally[4], status_tally[0], deepest);
        $display("Checking ended on %s, followed by %0d noise characters.",
                 terminal.name(), NOISE_ITEMS);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
design/isc_pkg.sv
design/isc_front.sv
design/isc_fifo.sv
design/isc_back.sv
design/indentation_stack_checker_unit.sv
sim/indentation_stack_checker_unit_tb.sv
